// File: rtl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// Typeahead FIFO package
// Shared types, control character codes and default sizes for the per-device
// typeahead queue with software flow control.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int QueueDepthDefault = 32;
  localparam int NumDevicesDefault = 3;

  localparam logic [7:0] CH_ABORT  = 8'h03;
  localparam logic [7:0] CH_RESUME = 8'h11;
  localparam logic [7:0] CH_PAUSE  = 8'h13;
  localparam logic [7:0] CH_CANCEL = 8'h18;

  localparam logic REQ_RECEIVE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  device;
    logic [31:0] key_code;
  } req_t;

  typedef struct packed {
    logic [31:0] read_code;
    logic        read_valid;
    logic        bell;
    logic        abort;
    logic        hold;
    logic        nonempty;
  } rsp_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

// File: rtl/tfc_queue_mem.sv
// ----------------------------------------------------------------------------
// Typeahead queue storage
// One synchronous memory holding every device's queue, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module tfc_queue_mem #(
  parameter int DEPTH  = 96,
  parameter int ADDR_W = 7
) (
  input  logic                clk,
  input  tfc_pkg::mem_cmd_t   cmd,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [31:0]         wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [31:0]         rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/tfc_ctrl.sv
// ----------------------------------------------------------------------------
// Typeahead queue control
// Per-device head, tail, fill count and hold flag; decodes control
// characters, issues queue memory accesses and registers the result flags.
// ----------------------------------------------------------------------------
module tfc_ctrl #(
  parameter int QUEUE_DEPTH = tfc_pkg::QueueDepthDefault,
  parameter int NUM_DEVICES = tfc_pkg::NumDevicesDefault,
  parameter int ADDR_W      = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  tfc_pkg::req_t       req,
  output tfc_pkg::mem_cmd_t   cmd,
  output logic [ADDR_W-1:0]   wr_addr,
  output logic [ADDR_W-1:0]   rd_addr,
  output logic                strobe,
  output tfc_pkg::rsp_t       flags
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DIDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [3:0]       DEV_LIMIT = 4'(NUM_DEVICES);

  logic [PTR_W-1:0] head [NUM_DEVICES];
  logic [PTR_W-1:0] tail [NUM_DEVICES];
  logic [CNT_W-1:0] count [NUM_DEVICES];
  logic [NUM_DEVICES-1:0] hold;

  logic              dev_ok;
  logic [DIDX_W-1:0] dev;
  logic [PTR_W-1:0]  cur_head;
  logic [PTR_W-1:0]  cur_tail;
  logic [CNT_W-1:0]  cur_count;
  logic              cur_hold;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;
  logic [CNT_W-1:0]  count_next;
  logic              hold_next;
  logic              push;
  logic              pop;
  logic              bell_next;
  logic              abort_next;
  logic [PTR_W-1:0]  wr_ptr;
  logic [7:0]        ch;
  logic [ADDR_W-1:0] dev_base;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign dev_ok    = {2'b00, req.device} < DEV_LIMIT;
  assign dev       = DIDX_W'(req.device);
  assign cur_head  = head[dev];
  assign cur_tail  = tail[dev];
  assign cur_count = count[dev];
  assign cur_hold  = hold[dev];
  assign ch        = req.key_code[7:0];
  assign dev_base  = ADDR_W'(req.device) * ADDR_W'(QUEUE_DEPTH);

  always_comb begin
    head_next  = cur_head;
    tail_next  = cur_tail;
    count_next = cur_count;
    hold_next  = cur_hold;
    push       = 1'b0;
    pop        = 1'b0;
    bell_next  = 1'b0;
    abort_next = 1'b0;
    wr_ptr     = cur_tail;
    if (req.req_type == tfc_pkg::REQ_RECEIVE) begin
      priority if (ch == tfc_pkg::CH_ABORT) begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
        hold_next  = 1'b0;
        abort_next = 1'b1;
      end else if (ch == tfc_pkg::CH_PAUSE) begin
        hold_next = 1'b1;
      end else if (ch == tfc_pkg::CH_RESUME) begin
        hold_next = 1'b0;
      end else if (ch == tfc_pkg::CH_CANCEL) begin
        push       = 1'b1;
        wr_ptr     = '0;
        head_next  = '0;
        tail_next  = PTR_W'(1);
        count_next = CNT_W'(1);
      end else if (cur_count == CNT_FULL) begin
        bell_next = 1'b1;
      end else begin
        push       = 1'b1;
        tail_next  = wrap_inc(cur_tail);
        count_next = cur_count + CNT_W'(1);
      end
    end else if (cur_count != '0) begin
      pop        = 1'b1;
      count_next = cur_count - CNT_W'(1);
      if (count_next == '0) begin
        head_next = '0;
        tail_next = '0;
      end else begin
        head_next = wrap_inc(cur_head);
      end
    end
  end

  assign cmd.wr_en = accept && dev_ok && push;
  assign cmd.rd_en = accept && dev_ok && pop;
  assign wr_addr   = dev_base + ADDR_W'(wr_ptr);
  assign rd_addr   = dev_base + ADDR_W'(cur_head);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
      hold   <= '0;
      strobe <= 1'b0;
      flags  <= '0;
    end else begin
      strobe <= accept;
      if (accept) begin
        flags <= '0;
        if (dev_ok) begin
          head[dev]        <= head_next;
          tail[dev]        <= tail_next;
          count[dev]       <= count_next;
          hold[dev]        <= hold_next;
          flags.read_valid <= pop;
          flags.bell       <= bell_next;
          flags.abort      <= abort_next;
          flags.hold       <= hold_next;
          flags.nonempty   <= count_next != '0;
        end
      end
    end
  end

endmodule

// File: rtl/typeahead_fifo_flow_control.sv
// ----------------------------------------------------------------------------
// Typeahead FIFO with flow control
// Per-device receive queues with Ctrl-C abort, Ctrl-S/Ctrl-Q hold and
// Ctrl-X cancel, plus reads of the oldest queued code.
//
// A request is transferred at a rising edge with start high and busy low.
// A receive request queues or interprets the code for its device; a read
// request pops that device's oldest code. Each request produces exactly one
// result, shown on rsp with strobe high in the cycle after the transfer.
// The receiver takes every result; there is no back-pressure.
// Results are registered, the read code by the read port of the queue
// memory. A new request may be transferred in every cycle while busy is low,
// since each request touches the memory at most once.
// Reset empties all queues and clears all hold flags at once; busy is high
// during reset and in the cycle following it.
// Requests naming a device beyond the configured count give an all-zero
// result and change nothing.
// ----------------------------------------------------------------------------
module typeahead_fifo_flow_control #(
  parameter int QUEUE_DEPTH = tfc_pkg::QueueDepthDefault,
  parameter int NUM_DEVICES = tfc_pkg::NumDevicesDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tfc_pkg::req_t  req,
  output logic           strobe,
  output tfc_pkg::rsp_t  rsp
);

  localparam int MEM_DEPTH = NUM_DEVICES * QUEUE_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  tfc_pkg::mem_cmd_t cmd;
  tfc_pkg::rsp_t     flags;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_data;
  logic              accept;
  logic              warmup;

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup <= 1'b1;
    end else begin
      warmup <= 1'b0;
    end
  end

  assign busy   = rst || warmup;
  assign accept = start && !busy;

  tfc_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_DEVICES (NUM_DEVICES),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .strobe  (strobe),
    .flags   (flags)
  );

  tfc_queue_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .wr_data (req.key_code),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rsp           = flags;
    rsp.read_code = flags.read_valid ? rd_data : 32'd0;
  end

endmodule
